@@ src/sha1md_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sha1md_pkg
// Shared types and constants of the SHA-1 digest block: working-variable
// struct, initial chain value, round constants and sequencer states.
// ----------------------------------------------------------------------------
package sha1md_pkg;

	typedef logic [31:0] word_t;
	typedef logic [6:0]  round_t;
	typedef logic [2:0]  widx_t;
	typedef logic [7:0]  byte_t;

	// a..e working variables, also used for the five chain words h0..h4
	typedef struct packed {
		word_t a;
		word_t b;
		word_t c;
		word_t d;
		word_t e;
	} work_t;

	localparam work_t H_INIT = '{
		a: 32'h67452301,
		b: 32'hEFCDAB89,
		c: 32'h98BADCFE,
		d: 32'h10325476,
		e: 32'hC3D2E1F0
	};

	localparam word_t K_CH  = 32'h5A827999;
	localparam word_t K_PAR = 32'h6ED9EBA1;
	localparam word_t K_MAJ = 32'h8F1BBCDC;
	localparam word_t K_PAR2 = 32'hCA62C1D6;

	localparam round_t ROUND_PAR  = 7'd20;
	localparam round_t ROUND_MAJ  = 7'd40;
	localparam round_t ROUND_PAR2 = 7'd60;
	localparam round_t LAST_ROUND = 7'd79;

	localparam byte_t      MARKER_BYTE = 8'h80;
	localparam logic [5:0] LEN_START   = 6'd56;
	localparam logic [5:0] LAST_SLOT   = 6'd63;
	localparam widx_t      LAST_WORD_IDX = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ROUND,
		ST_FINAL,
		ST_EMIT
	} state_t;

endpackage : sha1md_pkg
`default_nettype wire

@@ src/sha1md_in_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sha1md_in_if
// Message channel: one byte per beat with a presence flag and end flag.
// ----------------------------------------------------------------------------
interface sha1md_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] message_byte;
	logic       byte_present;
	logic       is_last;

	modport source (output valid, message_byte, byte_present, is_last, input ready);
	modport sink   (input valid, message_byte, byte_present, is_last, output ready);
endinterface : sha1md_in_if
`default_nettype wire

@@ src/sha1md_out_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sha1md_out_if
// Digest channel: one 32-bit digest word per beat, with its position.
// ----------------------------------------------------------------------------
interface sha1md_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface : sha1md_out_if
`default_nettype wire

@@ src/sha1_message_digest.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sha1_message_digest
// SHA-1 over a byte stream, one round per cycle on a shared round unit.
// ----------------------------------------------------------------------------
// Data bytes are taken one per cycle, and ready stays up between them. Every
// 64th byte starts the compression: the rounds, then a final step that folds
// the result into the chain, and no beat is taken meanwhile. An end beat
// then shifts in the padding one byte per cycle (64 minus the bytes held),
// compresses, and, when the marker lands in the last eight slots, pads and
// compresses one more block. The five digest words follow
// as five output beats, word 0 first; after the fifth the chain starts over.
// The bound on all of this is the single round unit, one round a cycle, and
// the single byte-wide shift path into the 512-bit block window.
// ----------------------------------------------------------------------------
module sha1_message_digest #(
	parameter int LENGTH_BITS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	sha1md_in_if.sink   msg,
	sha1md_out_if.source dig
);
	import sha1md_pkg::*;

	state_t state_q, state_d;

	logic [511:0]           win_q;
	logic [5:0]             fill_q;
	logic [LENGTH_BITS-1:0] cnt_q;
	work_t                  h_q;
	work_t                  v_q;
	work_t                  v_nxt;
	word_t                  w_new;
	round_t                 round_q;
	widx_t                  idx_q;
	logic                   last_q;
	logic                   marker_q;
	logic                   spill_q;

	logic        take;
	logic        shift_in;
	logic        blk_full;
	logic        emit_beat;
	logic [63:0] len64;
	byte_t       len_byte;
	byte_t       pad_byte;
	byte_t       shift_byte;

	sha1md_round u_round (
		.round (round_q),
		.cur   (v_q),
		.w0    (win_q[511:480]),
		.w2    (win_q[447:416]),
		.w8    (win_q[255:224]),
		.w13   (win_q[95:64]),
		.nxt   (v_nxt),
		.w_new (w_new)
	);

	// padding byte for the current slot
	assign len64    = 64'(cnt_q);
	assign len_byte = 8'(len64 >> {~fill_q[2:0], 3'b000});

	always_comb begin
		priority if (marker_q) begin
			pad_byte = MARKER_BYTE;
		end else if (fill_q >= LEN_START && !spill_q) begin
			pad_byte = len_byte;
		end else begin
			pad_byte = '0;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (take) begin
					if (msg.byte_present && fill_q == LAST_SLOT) begin
						state_d = ST_ROUND;
					end else if (msg.is_last) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				if (fill_q == LAST_SLOT) begin
					state_d = ST_ROUND;
				end
			end
			ST_ROUND: begin
				if (round_q == LAST_ROUND) begin
					state_d = ST_FINAL;
				end
			end
			ST_FINAL: begin
				if (!last_q) begin
					state_d = ST_IDLE;
				end else if (marker_q || spill_q) begin
					state_d = ST_PAD;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (dig.ready && idx_q == LAST_WORD_IDX) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs and strobes
	always_comb begin
		msg.ready  = (state_q == ST_IDLE);
		dig.valid  = (state_q == ST_EMIT);
		take       = msg.valid && msg.ready;
		shift_in   = (state_q == ST_PAD) || (take && msg.byte_present);
		shift_byte = (state_q == ST_PAD) ? pad_byte : msg.message_byte;
		blk_full   = shift_in && fill_q == LAST_SLOT;
		emit_beat  = dig.valid && dig.ready;
		dig.word_index = idx_q;
		dig.last_word  = (idx_q == LAST_WORD_IDX);
		unique case (idx_q)
			3'd0:    dig.digest_word = h_q.a;
			3'd1:    dig.digest_word = h_q.b;
			3'd2:    dig.digest_word = h_q.c;
			3'd3:    dig.digest_word = h_q.d;
			3'd4:    dig.digest_word = h_q.e;
			default: dig.digest_word = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			fill_q   <= '0;
			cnt_q    <= '0;
			h_q      <= H_INIT;
			round_q  <= '0;
			idx_q    <= '0;
			last_q   <= 1'b0;
			marker_q <= 1'b0;
			spill_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (shift_in) begin
				fill_q <= fill_q + 6'd1;
			end
			if (take && msg.byte_present) begin
				cnt_q <= cnt_q + LENGTH_BITS'(8);
			end
			if (take && msg.is_last) begin
				last_q   <= 1'b1;
				marker_q <= 1'b1;
			end
			if (state_q == ST_PAD && marker_q) begin
				marker_q <= 1'b0;
				// marker in the length field: length goes to a spill block
				if (fill_q >= LEN_START) begin
					spill_q <= 1'b1;
				end
			end
			if (blk_full) begin
				round_q <= '0;
			end else if (state_q == ST_ROUND) begin
				round_q <= round_q + 7'd1;
			end
			if (state_q == ST_FINAL) begin
				h_q.a   <= h_q.a + v_q.a;
				h_q.b   <= h_q.b + v_q.b;
				h_q.c   <= h_q.c + v_q.c;
				h_q.d   <= h_q.d + v_q.d;
				h_q.e   <= h_q.e + v_q.e;
				spill_q <= 1'b0;
			end
			if (emit_beat) begin
				if (idx_q == LAST_WORD_IDX) begin
					idx_q  <= '0;
					h_q    <= H_INIT;
					cnt_q  <= '0;
					last_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 3'd1;
				end
			end
		end
	end

	// block window doubles as the message schedule
	always_ff @(posedge clk) begin
		if (shift_in) begin
			win_q <= {win_q[503:0], shift_byte};
		end else if (state_q == ST_ROUND) begin
			win_q <= {win_q[479:0], w_new};
		end
		if (blk_full) begin
			v_q <= h_q;
		end else if (state_q == ST_ROUND) begin
			v_q <= v_nxt;
		end
	end

endmodule : sha1_message_digest
`default_nettype wire

@@ src/sha1md_round.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sha1md_round
// One SHA-1 round: round function, constant select, new a, and the next
// message schedule word from the window taps.
// ----------------------------------------------------------------------------
module sha1md_round (
	input  sha1md_pkg::round_t round,
	input  sha1md_pkg::work_t  cur,
	input  sha1md_pkg::word_t  w0,
	input  sha1md_pkg::word_t  w2,
	input  sha1md_pkg::word_t  w8,
	input  sha1md_pkg::word_t  w13,
	output sha1md_pkg::work_t  nxt,
	output sha1md_pkg::word_t  w_new
);
	import sha1md_pkg::*;

	word_t f;
	word_t k;
	word_t t;
	word_t x;

	always_comb begin
		priority if (round < ROUND_PAR) begin
			f = (cur.b & cur.c) | (~cur.b & cur.d);
			k = K_CH;
		end else if (round < ROUND_MAJ) begin
			f = cur.b ^ cur.c ^ cur.d;
			k = K_PAR;
		end else if (round < ROUND_PAR2) begin
			f = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
			k = K_MAJ;
		end else begin
			f = cur.b ^ cur.c ^ cur.d;
			k = K_PAR2;
		end
	end

	assign t = {cur.a[26:0], cur.a[31:27]} + f + cur.e + k + w0;

	always_comb begin
		nxt.a = t;
		nxt.b = cur.a;
		nxt.c = {cur.b[1:0], cur.b[31:2]};
		nxt.d = cur.c;
		nxt.e = cur.d;
	end

	// window holds W[i..i+15]; this yields W[i+16]
	assign x     = w13 ^ w8 ^ w2 ^ w0;
	assign w_new = {x[30:0], x[31]};

endmodule : sha1md_round
`default_nettype wire

@@ verif/tb_sha1_message_digest.sv @@
// ----------------------------------------------------------------------------
// tb_sha1_message_digest
// Feeds byte-wide messages into the SHA-1 digest block and checks the five
// digest words of each message against its known or in-bench SHA-1 digest. The
// sender runs in bursts, and the digest receiver stalls on a rotating pattern.
// ----------------------------------------------------------------------------
module tb_sha1_message_digest;

	import sha1md_pkg::*;

	localparam int LENGTH_BITS = 64;
	localparam logic [63:0] BITS_MASK = {64{1'b1}} >> (64 - LENGTH_BITS);

	localparam logic [159:0] EMPTY_DGST = 160'hda39a3ee5e6b4b0d3255bfef95601890afd80709;
	localparam logic [159:0] ABC_DGST   = 160'ha9993e364706816aba3e25717850c26c9cd0d89d;
	localparam logic [159:0] NO_DGST    = '0;

	typedef struct packed {
		byte_t        data;
		logic         present;
		logic         last;
		logic         known;
		logic [159:0] dgst;
	} dir_row_t;

	localparam int N_DIR = 17;
	localparam dir_row_t DIR_ROWS [N_DIR] = '{
		'{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DGST},	// empty message
		'{8'h5a, 1'b0, 1'b0, 1'b0, NO_DGST},	// idle beat
		'{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DGST},
		'{8'h61, 1'b1, 1'b0, 1'b0, NO_DGST},
		'{8'h62, 1'b1, 1'b0, 1'b0, NO_DGST},
		'{8'h63, 1'b1, 1'b1, 1'b1, ABC_DGST},	// end flag on the data byte
		'{8'hff, 1'b0, 1'b0, 1'b0, NO_DGST},
		'{8'h61, 1'b1, 1'b0, 1'b0, NO_DGST},
		'{8'h62, 1'b1, 1'b0, 1'b0, NO_DGST},
		'{8'h63, 1'b1, 1'b0, 1'b0, NO_DGST},
		'{8'ha5, 1'b0, 1'b1, 1'b1, ABC_DGST},	// bare end, byte must be ignored
		'{8'hff, 1'b1, 1'b1, 1'b0, NO_DGST},
		'{8'h00, 1'b1, 1'b0, 1'b0, NO_DGST},
		'{8'hff, 1'b0, 1'b0, 1'b0, NO_DGST},	// idle in mid-message
		'{8'hff, 1'b1, 1'b0, 1'b0, NO_DGST},
		'{8'h00, 1'b0, 1'b1, 1'b0, NO_DGST},
		'{8'h00, 1'b1, 1'b1, 1'b0, NO_DGST}
	};

	typedef struct packed {
		word_t word;
		widx_t idx;
		logic  last;
	} digest_beat_t;

	logic clk;
	logic arst_n;

	sha1md_in_if  msg_if ();
	sha1md_out_if dig_if ();

	sha1_message_digest #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.msg   (msg_if),
		.dig   (dig_if)
	);

	// predictor state
	byte_t        msg_block [64];
	work_t        chain_h;
	logic [63:0]  msg_bits;
	int           msg_fill;

	digest_beat_t pending_words [$];
	int           err_count;
	int           burst_left;
	logic [15:0]  stall_pat;
	int unsigned  stall_tick;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

	function automatic void sha1_compress();
		word_t w [16];
		word_t a, b, c, d, e, f, k, t, x;
		for (int i = 0; i < 16; i++)
			w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
		a = chain_h.a;
		b = chain_h.b;
		c = chain_h.c;
		d = chain_h.d;
		e = chain_h.e;
		for (int i = 0; i < 80; i++) begin
			if (i >= 16) begin
				x = w[(i-3) & 15] ^ w[(i-8) & 15] ^ w[(i-14) & 15] ^ w[i & 15];
				w[i & 15] = {x[30:0], x[31]};
			end
			if (i < ROUND_PAR) begin
				f = (b & c) | (~b & d);
				k = K_CH;
			end else if (i < ROUND_MAJ) begin
				f = b ^ c ^ d;
				k = K_PAR;
			end else if (i < ROUND_PAR2) begin
				f = (b & c) | (b & d) | (c & d);
				k = K_MAJ;
			end else begin
				f = b ^ c ^ d;
				k = K_PAR2;
			end
			t = {a[26:0], a[31:27]} + f + e + k + w[i & 15];
			e = d;
			d = c;
			c = {b[1:0], b[31:2]};
			b = a;
			a = t;
		end
		chain_h.a += a;
		chain_h.b += b;
		chain_h.c += c;
		chain_h.d += d;
		chain_h.e += e;
	endfunction

	// absorb one accepted beat; returns 1 with the digest when the message ends
	function automatic bit sha1_absorb(input byte_t data, input bit present, input bit last,
			output logic [159:0] dgst);
		int pos;
		dgst = '0;
		if (present) begin
			msg_block[msg_fill] = data;
			msg_fill++;
			msg_bits = (msg_bits + 64'd8) & BITS_MASK;
			if (msg_fill == 64) begin
				sha1_compress();
				msg_fill = 0;
			end
		end
		if (!last)
			return 1'b0;
		pos = msg_fill;
		msg_block[pos] = MARKER_BYTE;
		pos++;
		// marker in the length slots: pad out and spill into one more block
		if (pos > LEN_START) begin
			while (pos < 64) begin
				msg_block[pos] = 8'h00;
				pos++;
			end
			sha1_compress();
			pos = 0;
		end
		while (pos < LEN_START) begin
			msg_block[pos] = 8'h00;
			pos++;
		end
		for (int i = 0; i < 8; i++)
			msg_block[LEN_START + i] = msg_bits[63 - 8*i -: 8];
		sha1_compress();
		dgst = chain_h;
		chain_h = H_INIT;
		msg_bits = '0;
		msg_fill = 0;
		return 1'b1;
	endfunction

	task automatic send_beat(input byte_t data, input bit present, input bit last,
			input bit known, input logic [159:0] known_dgst);
		logic [159:0] dgst;
		int gap;
		if (burst_left == 0) begin
			msg_if.valid <= 1'b0;
			gap = $urandom_range(1, 8);
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
			                                         : $urandom_range(1, 8);
		end
		msg_if.valid        <= 1'b1;
		msg_if.message_byte <= data;
		msg_if.byte_present <= present;
		msg_if.is_last      <= last;
		do @(posedge clk); while (!msg_if.ready);
		burst_left--;
		if (sha1_absorb(data, present, last, dgst)) begin
			if (known)
				dgst = known_dgst;
			for (int i = 0; i < 5; i++)
				pending_words.push_back('{dgst[159 - 32*i -: 32], widx_t'(i),
				                         widx_t'(i) == LAST_WORD_IDX});
		end
	endtask

	// digest receiver: rotating stall pattern, reloaded each time the low seven bits of stall_tick are zero
	always @(posedge clk) begin
		digest_beat_t exp_beat;
		if (stall_tick[6:0] == 7'd0) begin
			case ($urandom_range(0, 3))
				0: stall_pat = 16'hffff;
				1: stall_pat = 16'($urandom() & $urandom()) | 16'h1;
				default: stall_pat = 16'($urandom()) | 16'h1;
			endcase
		end
		stall_tick++;
		stall_pat = {stall_pat[14:0], stall_pat[15]};
		dig_if.ready <= stall_pat[0];

		if (arst_n && dig_if.valid && dig_if.ready) begin
			if (pending_words.size() == 0) begin
				$display("%0t: unexpected digest beat: got word %h index %0d last %b",
				         $time, dig_if.digest_word, dig_if.word_index, dig_if.last_word);
				err_count++;
			end else begin
				exp_beat = pending_words.pop_front();
				if (dig_if.digest_word !== exp_beat.word || dig_if.word_index !== exp_beat.idx ||
				    dig_if.last_word !== exp_beat.last) begin
					$display("%0t: digest mismatch: expected word %h index %0d last %b, got word %h index %0d last %b",
					         $time, exp_beat.word, exp_beat.idx, exp_beat.last,
					         dig_if.digest_word, dig_if.word_index, dig_if.last_word);
					err_count++;
				end
			end
		end
	end

	initial begin
		int n_msgs;
		int len;
		bit bare_end;
		int drain;

		err_count  = 0;
		burst_left = 0;
		stall_pat  = 16'hffff;
		stall_tick = 0;
		chain_h    = H_INIT;
		msg_bits   = '0;
		msg_fill   = 0;
		dig_if.ready        = 1'b0;
		msg_if.valid        = 1'b0;
		msg_if.message_byte = '0;
		msg_if.byte_present = 1'b0;
		msg_if.is_last      = 1'b0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < N_DIR; r++)
			send_beat(DIR_ROWS[r].data, DIR_ROWS[r].present, DIR_ROWS[r].last,
			          DIR_ROWS[r].known, DIR_ROWS[r].dgst);

		// random messages: a spill block, a block boundary, then a short one
		n_msgs = 0;
		while (n_msgs < 3) begin
			if (n_msgs == 0)
				len = $urandom_range(56, 63);
			else if (n_msgs == 1)
				len = $urandom_range(64, 66);
			else
				len = $urandom_range(0, 8);
			bare_end = (len == 0) || ($urandom_range(0, 2) == 0);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 7) == 0)
					send_beat(byte_t'($urandom), 1'b0, 1'b0, 1'b0, NO_DGST);
				send_beat(byte_t'($urandom), 1'b1, !bare_end && (i == len - 1), 1'b0, NO_DGST);
			end
			if (bare_end)
				send_beat(byte_t'($urandom), 1'b0, 1'b1, 1'b0, NO_DGST);
			n_msgs++;
		end
		msg_if.valid <= 1'b0;

		drain = 0;
		while (pending_words.size() != 0 && drain < 100_000) begin
			@(posedge clk);
			drain++;
		end
		if (pending_words.size() != 0) begin
			$display("%0t: %0d digest words never arrived", $time, pending_words.size());
			err_count++;
		end
		repeat (200) @(posedge clk);

		if (err_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule : tb_sha1_message_digest
